/* sv/timed_event_priority_queue_defines.svh */
`ifndef TIMED_EVENT_PRIORITY_QUEUE_DEFINES_SVH
`define TIMED_EVENT_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, held off while reset is low.
`define TEPQ_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, held off while reset is low.
`define TEPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* sv/tepq_pkg.sv */
package tepq_pkg;

    localparam int DEPTH       = 64;
    localparam int TIME_BITS   = 32;
    localparam int TARGET_BITS = 16;
    localparam int CNT_BITS    = 7;

    typedef enum logic [1:0] {
        FN_INSERT   = 2'd0,
        FN_ADV_NEXT = 2'd1,
        FN_ADV_TIME = 2'd2,
        FN_CLEAR    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        STS_INSERTED = 3'd0,
        STS_FIRED    = 3'd1,
        STS_NOTHING  = 3'd2,
        STS_EMPTY    = 3'd3,
        STS_FULL     = 3'd4,
        STS_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIRE
    } t_state;

    typedef struct packed {
        logic [TIME_BITS-1:0]   evt_time;
        logic [TARGET_BITS-1:0] tgt;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry entry;
    } t_cell_cmd;

    typedef struct packed {
        t_status                status;
        logic [TARGET_BITS-1:0] fired_target;
        logic [TIME_BITS-1:0]   fired_time;
        logic [TIME_BITS-1:0]   clock_now;
        logic [CNT_BITS-1:0]    pending_count;
        logic                   group_end;
        logic                   last;
    } t_result;

endpackage

/* sv/tepq_cell.sv */
module tepq_cell (
    input  logic                i_clk,
    input  tepq_pkg::t_cell_cmd i_cmd,
    input  logic                i_valid,
    input  logic                i_prev_gt,
    input  tepq_pkg::t_entry    i_prev,
    input  tepq_pkg::t_entry    i_next,
    output logic                o_gt,
    output tepq_pkg::t_entry    o_entry
);

    tepq_pkg::t_entry r_entry;
    tepq_pkg::t_entry n_entry;

    // empty cells and later times make room; equal times stay ahead
    assign o_gt    = !i_valid || (r_entry.evt_time > i_cmd.entry.evt_time);
    assign o_entry = r_entry;

    always_comb begin
        priority if (i_cmd.pop) begin
            n_entry = i_next;
        end else if (i_cmd.ins && i_prev_gt) begin
            n_entry = i_prev;
        end else if (i_cmd.ins && o_gt) begin
            n_entry = i_cmd.entry;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* sv/tepq_ctrl.sv */
module tepq_ctrl (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  tepq_pkg::t_func                       i_func,
    input  logic [tepq_pkg::TIME_BITS-1:0]        i_event_time,
    input  logic [tepq_pkg::TARGET_BITS-1:0]      i_target_id,
    input  tepq_pkg::t_entry                      i_head,
    input  tepq_pkg::t_entry                      i_second,
    output tepq_pkg::t_cell_cmd                   o_cmd,
    output logic [tepq_pkg::CNT_BITS-1:0]         o_count,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output tepq_pkg::t_result                     o_result
);

    tepq_pkg::t_state  r_state, n_state;
    tepq_pkg::t_func   r_func;
    logic [tepq_pkg::TIME_BITS-1:0]   r_tval;
    logic [tepq_pkg::TARGET_BITS-1:0] r_tgt;
    logic [tepq_pkg::TIME_BITS-1:0]   r_goal, n_goal;
    logic [tepq_pkg::TIME_BITS-1:0]   r_clock, n_clock;
    logic [tepq_pkg::TIME_BITS-1:0]   r_grp, n_grp;
    logic [tepq_pkg::CNT_BITS-1:0]    r_count, n_count;
    logic                             r_out_valid;
    tepq_pkg::t_result                r_out, n_out;
    logic [tepq_pkg::TIME_BITS:0]     w_sum;
    logic w_acc, w_emit_ok, w_emit, w_full, w_empty, w_head_due, w_grp_end, w_next_due;

    assign w_acc      = i_in_valid && (r_state == tepq_pkg::S_IDLE);
    assign w_emit_ok  = !r_out_valid || !i_out_stall;
    assign w_full     = (r_count == tepq_pkg::CNT_BITS'(tepq_pkg::DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_head_due = (i_head.evt_time <= r_goal);
    assign w_grp_end  = (r_count == tepq_pkg::CNT_BITS'(1)) || (i_second.evt_time != r_grp);
    assign w_next_due = (r_count > tepq_pkg::CNT_BITS'(1)) && (i_second.evt_time <= r_goal);
    assign w_sum      = {1'b0, r_clock} + {1'b0, i_event_time};
    assign n_goal     = w_sum[tepq_pkg::TIME_BITS] ? '1 : w_sum[tepq_pkg::TIME_BITS-1:0];

    assign o_in_stall  = (r_state != tepq_pkg::S_IDLE);
    assign o_count     = r_count;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tepq_pkg::S_IDLE: begin
                if (w_acc) n_state = tepq_pkg::S_EXEC;
            end
            tepq_pkg::S_EXEC: begin
                if (w_emit_ok) begin
                    unique case (r_func)
                        tepq_pkg::FN_INSERT,
                        tepq_pkg::FN_CLEAR:    n_state = tepq_pkg::S_IDLE;
                        tepq_pkg::FN_ADV_NEXT:
                            n_state = w_empty ? tepq_pkg::S_IDLE : tepq_pkg::S_FIRE;
                        tepq_pkg::FN_ADV_TIME:
                            n_state = (w_empty || !w_head_due) ? tepq_pkg::S_IDLE
                                                               : tepq_pkg::S_FIRE;
                        default:               n_state = tepq_pkg::S_IDLE;
                    endcase
                end
            end
            tepq_pkg::S_FIRE: begin
                if (w_emit_ok && w_grp_end &&
                    !((r_func == tepq_pkg::FN_ADV_TIME) && w_next_due)) begin
                    n_state = tepq_pkg::S_IDLE;
                end
            end
            default: n_state = tepq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_emit    = 1'b0;
        n_out     = '0;
        n_out.last = 1'b1;
        o_cmd     = '0;
        o_cmd.entry.evt_time = r_tval;
        o_cmd.entry.tgt      = r_tgt;
        n_count   = r_count;
        n_clock   = r_clock;
        n_grp     = r_grp;
        unique case (r_state)
            tepq_pkg::S_IDLE: begin
            end
            tepq_pkg::S_EXEC: begin
                if (w_emit_ok) begin
                    unique case (r_func)
                        tepq_pkg::FN_INSERT: begin
                            w_emit = 1'b1;
                            if (w_full) begin
                                n_out.status = tepq_pkg::STS_FULL;
                            end else begin
                                o_cmd.ins    = 1'b1;
                                n_count      = r_count + tepq_pkg::CNT_BITS'(1);
                                n_out.status = tepq_pkg::STS_INSERTED;
                            end
                        end
                        tepq_pkg::FN_CLEAR: begin
                            w_emit       = 1'b1;
                            n_count      = '0;
                            n_clock      = '0;
                            n_out.status = tepq_pkg::STS_CLEARED;
                        end
                        tepq_pkg::FN_ADV_NEXT: begin
                            if (w_empty) begin
                                w_emit       = 1'b1;
                                n_out.status = tepq_pkg::STS_EMPTY;
                            end else begin
                                n_grp   = i_head.evt_time;
                                n_clock = i_head.evt_time;
                            end
                        end
                        tepq_pkg::FN_ADV_TIME: begin
                            if (w_empty) begin
                                w_emit       = 1'b1;
                                n_clock      = r_goal;
                                n_out.status = tepq_pkg::STS_EMPTY;
                            end else if (!w_head_due) begin
                                w_emit       = 1'b1;
                                n_clock      = r_goal;
                                n_out.status = tepq_pkg::STS_NOTHING;
                            end else begin
                                n_grp   = i_head.evt_time;
                                n_clock = i_head.evt_time;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tepq_pkg::S_FIRE: begin
                if (w_emit_ok) begin
                    w_emit             = 1'b1;
                    o_cmd.pop          = 1'b1;
                    n_count            = r_count - tepq_pkg::CNT_BITS'(1);
                    n_clock            = r_grp;
                    n_out.status       = tepq_pkg::STS_FIRED;
                    n_out.fired_target = i_head.tgt;
                    n_out.fired_time   = r_grp;
                    n_out.group_end    = w_grp_end;
                    n_out.last         = 1'b0;
                    if (w_grp_end) begin
                        if (r_func == tepq_pkg::FN_ADV_TIME) begin
                            if (w_next_due) begin
                                n_grp = i_second.evt_time;
                            end else begin
                                n_clock    = r_goal;
                                n_out.last = 1'b1;
                            end
                        end else begin
                            n_out.last = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        n_out.clock_now     = n_clock;
        n_out.pending_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tepq_pkg::S_IDLE;
            r_count     <= '0;
            r_clock     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_clock <= n_clock;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        if (w_emit) r_out <= n_out;
        if (w_acc) begin
            r_func <= i_func;
            r_tval <= i_event_time;
            r_tgt  <= i_target_id;
            r_goal <= n_goal;
        end
    end

endmodule

/* sv/timed_event_priority_queue.sv */
// Event queue built as a sorted chain of cells; entries shift one cell per beat.
// Insert, clear, empty and nothing-due results are registered from the EXEC state; an
// advance that fires goes from EXEC to FIRE and shows its firings one per cycle while
// the result is not stalled. A new input beat is taken only in IDLE, so not before the
// last result of the previous command; a stalled result beat holds the sequencer.
// Reset (i_rst_n low, synchronous): queue empty, clock zero, no result pending.
module timed_event_priority_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_func,
    input  logic [tepq_pkg::TIME_BITS-1:0]      i_event_time,
    input  logic [tepq_pkg::TARGET_BITS-1:0]    i_target_id,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [2:0]                          o_status,
    output logic [tepq_pkg::TARGET_BITS-1:0]    o_fired_target,
    output logic [tepq_pkg::TIME_BITS-1:0]      o_fired_time,
    output logic [tepq_pkg::TIME_BITS-1:0]      o_clock_now,
    output logic [tepq_pkg::CNT_BITS-1:0]       o_pending_count,
    output logic                                o_group_end,
    output logic                                o_last
);

    tepq_pkg::t_cell_cmd              w_cmd;
    tepq_pkg::t_result                w_res;
    tepq_pkg::t_entry                 w_entry [tepq_pkg::DEPTH];
    logic [tepq_pkg::DEPTH-1:0]       w_gt;
    logic [tepq_pkg::CNT_BITS-1:0]    w_count;

    tepq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .o_in_stall   (o_stall),
        .i_func       (tepq_pkg::t_func'(i_func)),
        .i_event_time (i_event_time),
        .i_target_id  (i_target_id),
        .i_head       (w_entry[0]),
        .i_second     (w_entry[1]),
        .o_cmd        (w_cmd),
        .o_count      (w_count),
        .o_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .o_result     (w_res)
    );

    for (genvar i = 0; i < tepq_pkg::DEPTH; i++) begin : g_cell
        tepq_cell u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd),
            .i_valid   (tepq_pkg::CNT_BITS'(i) < w_count),
            .i_prev_gt ((i == 0) ? 1'b0 : w_gt[(i == 0) ? 0 : i-1]),
            .i_prev    ((i == 0) ? w_cmd.entry : w_entry[(i == 0) ? 0 : i-1]),
            .i_next    (w_entry[(i == tepq_pkg::DEPTH-1) ? i : i+1]),
            .o_gt      (w_gt[i]),
            .o_entry   (w_entry[i])
        );
    end

    assign o_status        = w_res.status;
    assign o_fired_target  = w_res.fired_target;
    assign o_fired_time    = w_res.fired_time;
    assign o_clock_now     = w_res.clock_now;
    assign o_pending_count = w_res.pending_count;
    assign o_group_end     = w_res.group_end;
    assign o_last          = w_res.last;

endmodule

/* sv/tepq_checker.sv */
`include "timed_event_priority_queue_defines.svh"

module tepq_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic [1:0]                          i_func,
    input logic [tepq_pkg::TIME_BITS-1:0]      i_event_time,
    input logic [tepq_pkg::TARGET_BITS-1:0]    i_target_id,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [2:0]                          o_status,
    input logic [tepq_pkg::TARGET_BITS-1:0]    o_fired_target,
    input logic [tepq_pkg::TIME_BITS-1:0]      o_fired_time,
    input logic [tepq_pkg::TIME_BITS-1:0]      o_clock_now,
    input logic [tepq_pkg::CNT_BITS-1:0]       o_pending_count,
    input logic                                o_group_end,
    input logic                                o_last
);

    `TEPQ_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall,
        i_valid && $stable(i_func) && $stable(i_event_time) && $stable(i_target_id))
    `TEPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_status) && $stable(o_fired_target) &&
        $stable(o_clock_now) && $stable(o_last))
    `TEPQ_ASSERT(a_nonfire_clean, i_clk, i_rst_n,
        o_valid && (o_status != tepq_pkg::STS_FIRED),
        o_last && !o_group_end && (o_fired_target == '0) && (o_fired_time == '0))
    `TEPQ_ASSERT(a_cleared_zero, i_clk, i_rst_n,
        o_valid && (o_status == tepq_pkg::STS_CLEARED),
        (o_pending_count == '0) && (o_clock_now == '0))
    `TEPQ_ASSERT(a_last_closes_grp, i_clk, i_rst_n,
        o_valid && (o_status == tepq_pkg::STS_FIRED) && o_last, o_group_end)

endmodule

bind timed_event_priority_queue tepq_checker u_tepq_checker (.*);

/* tb/tb_timed_event_priority_queue.sv */
`timescale 1ns / 1ps

module tb_timed_event_priority_queue;

    localparam int PH_FREE       = 0;
    localparam int PH_SEND_IDLE  = 1;
    localparam int PH_RECV_STALL = 2;
    localparam int PH_BOTH       = 3;
    localparam int PH_PRESSURE   = 4;

    localparam int RANDOM_ITEMS = 450;
    localparam int PHASE_ITEMS  = 90;
    localparam int HOLD_CYCLES  = 600;
    localparam int WATCHDOG     = 5000;
    localparam int DRAIN        = 20;

    typedef struct {
        tepq_pkg::t_func                  func;
        logic [tepq_pkg::TIME_BITS-1:0]   tval;
        logic [tepq_pkg::TARGET_BITS-1:0] id;
        int                               phase;
    } t_request;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_stall;
    logic [1:0]                       i_func = 2'd0;
    logic [tepq_pkg::TIME_BITS-1:0]   i_event_time = '0;
    logic [tepq_pkg::TARGET_BITS-1:0] i_target_id = '0;
    logic                             o_valid;
    logic                             i_stall = 1'b0;
    logic [2:0]                       o_status;
    logic [tepq_pkg::TARGET_BITS-1:0] o_fired_target;
    logic [tepq_pkg::TIME_BITS-1:0]   o_fired_time;
    logic [tepq_pkg::TIME_BITS-1:0]   o_clock_now;
    logic [tepq_pkg::CNT_BITS-1:0]    o_pending_count;
    logic                             o_group_end;
    logic                             o_last;

    t_request                       request_q[$];
    tepq_pkg::t_entry               event_list[$];
    tepq_pkg::t_result              outcome_q[$];
    logic [tepq_pkg::TIME_BITS-1:0] shadow_clock = '0;

    int send_idle_pct [5] = '{0, 83, 0, 26, 0};
    int recv_stall_pct [5] = '{0, 0, 83, 26, 0};
    int live_phase = PH_FREE;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stuck_cycles = 0;
    int err_cnt = 0;
    int n_req = 0;
    int n_fired = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_nothing = 0;
    int n_cleared = 0;
    logic timed_out;

    timed_event_priority_queue u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_event_time    (i_event_time),
        .i_target_id     (i_target_id),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_fired_target  (o_fired_target),
        .o_fired_time    (o_fired_time),
        .o_clock_now     (o_clock_now),
        .o_pending_count (o_pending_count),
        .o_group_end     (o_group_end),
        .o_last          (o_last)
    );

    always #4 i_clk = ~i_clk;

    function automatic void post_outcome(tepq_pkg::t_status st,
                                         logic [tepq_pkg::TARGET_BITS-1:0] tgt,
                                         logic [tepq_pkg::TIME_BITS-1:0] tim, logic grp);
        tepq_pkg::t_result r;
        r.status        = st;
        r.fired_target  = tgt;
        r.fired_time    = tim;
        r.clock_now     = shadow_clock;
        r.pending_count = tepq_pkg::CNT_BITS'(event_list.size());
        r.group_end     = grp;
        r.last          = 1'b0;
        outcome_q = {outcome_q, r};
    endfunction

    function automatic void fire_head_group();
        logic [tepq_pkg::TIME_BITS-1:0] t;
        tepq_pkg::t_entry               e;
        logic                           grp;
        t = event_list[0].evt_time;
        shadow_clock = t;
        while (event_list.size() > 0 && event_list[0].evt_time == t) begin
            e = event_list.pop_front();
            grp = (event_list.size() == 0) || (event_list[0].evt_time != t);
            post_outcome(tepq_pkg::STS_FIRED, e.tgt, t, grp);
        end
    endfunction

    // shadow scheduler: applies one accepted request, queues its outcomes
    function automatic void apply_request(tepq_pkg::t_func f,
                                          logic [tepq_pkg::TIME_BITS-1:0] tv,
                                          logic [tepq_pkg::TARGET_BITS-1:0] id);
        int                             p;
        int                             n0;
        tepq_pkg::t_entry               e;
        tepq_pkg::t_result              r;
        logic [tepq_pkg::TIME_BITS:0]   sum;
        logic [tepq_pkg::TIME_BITS-1:0] goal;
        n0 = outcome_q.size();
        case (f)
            tepq_pkg::FN_INSERT: begin
                if (event_list.size() >= tepq_pkg::DEPTH) begin
                    post_outcome(tepq_pkg::STS_FULL, '0, '0, 1'b0);
                end else begin
                    p = 0;
                    while (p < event_list.size() && event_list[p].evt_time <= tv) p++;
                    e.evt_time = tv;
                    e.tgt = id;
                    event_list.insert(p, e);
                    post_outcome(tepq_pkg::STS_INSERTED, '0, '0, 1'b0);
                end
            end
            tepq_pkg::FN_ADV_NEXT: begin
                if (event_list.size() == 0) post_outcome(tepq_pkg::STS_EMPTY, '0, '0, 1'b0);
                else fire_head_group();
            end
            tepq_pkg::FN_ADV_TIME: begin
                sum = {1'b0, shadow_clock} + {1'b0, tv};
                goal = sum[tepq_pkg::TIME_BITS] ? '1 : sum[tepq_pkg::TIME_BITS-1:0];
                if (event_list.size() == 0) begin
                    shadow_clock = goal;
                    post_outcome(tepq_pkg::STS_EMPTY, '0, '0, 1'b0);
                end else begin
                    while (event_list.size() > 0 && event_list[0].evt_time <= goal)
                        fire_head_group();
                    shadow_clock = goal;
                    if (outcome_q.size() == n0) begin
                        post_outcome(tepq_pkg::STS_NOTHING, '0, '0, 1'b0);
                    end else begin
                        r = outcome_q[outcome_q.size() - 1];
                        r.clock_now = shadow_clock;
                        outcome_q[outcome_q.size() - 1] = r;
                    end
                end
            end
            default: begin
                event_list.delete();
                shadow_clock = '0;
                post_outcome(tepq_pkg::STS_CLEARED, '0, '0, 1'b0);
            end
        endcase
        r = outcome_q[outcome_q.size() - 1];
        r.last = 1'b1;
        outcome_q[outcome_q.size() - 1] = r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    task automatic push_req(input tepq_pkg::t_func f,
                            input logic [tepq_pkg::TIME_BITS-1:0] tv,
                            input logic [tepq_pkg::TARGET_BITS-1:0] id, input int ph);
        t_request r;
        r.func = f;
        r.tval = tv;
        r.id = id;
        r.phase = ph;
        request_q = {request_q, r};
    endtask

    // one burst: mostly a batch of inserts with shared times followed by advances
    task automatic push_burst(input int ph);
        int                             kind;
        int                             n;
        int                             span;
        logic [tepq_pkg::TIME_BITS-1:0] base;
        kind = $urandom_range(99);
        if (kind < 70) begin
            n = $urandom_range(1, 12);
            base = $urandom_range(0, 3000);
            span = $urandom_range(1, 40);
            repeat (n) begin
                if ($urandom_range(99) < 5)
                    push_req(tepq_pkg::FN_INSERT, $urandom, $urandom_range(0, 65535), ph);
                else
                    push_req(tepq_pkg::FN_INSERT, base + $urandom_range(0, 3) * span,
                             $urandom_range(0, 65535), ph);
            end
            n = $urandom_range(1, 4);
            repeat (n) begin
                if ($urandom_range(1))
                    push_req(tepq_pkg::FN_ADV_NEXT, $urandom, $urandom_range(0, 65535), ph);
                else
                    push_req(tepq_pkg::FN_ADV_TIME, $urandom_range(0, 400),
                             $urandom_range(0, 65535), ph);
            end
        end else if (kind < 80) begin
            push_req(tepq_pkg::t_func'($urandom_range(0, 3)), $urandom,
                     $urandom_range(0, 65535), ph);
        end else if (kind < 85) begin
            push_req(tepq_pkg::FN_CLEAR, $urandom, $urandom_range(0, 65535), ph);
        end else if (kind < 90) begin
            push_req(tepq_pkg::FN_ADV_TIME, $urandom, $urandom_range(0, 65535), ph);
        end else begin
            push_req(tepq_pkg::FN_INSERT, $urandom, $urandom_range(0, 65535), ph);
        end
    endtask

    // driver
    always @(posedge i_clk) begin : drive
        t_request req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                apply_request(tepq_pkg::t_func'(i_func), i_event_time, i_target_id);
                n_req++;
            end
            if (!i_valid || !o_stall) begin
                if (request_q.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct[request_q[0].phase]) begin
                    req = request_q.pop_front();
                    i_func <= req.func;
                    i_event_time <= req.tval;
                    i_target_id <= req.id;
                    i_valid <= 1'b1;
                    live_phase <= req.phase;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : watch
        tepq_pkg::t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (outcome_q.size() == 0) begin
                    $error("unexpected result beat, status %0d", o_status);
                    err_cnt++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("fired_target", want.fired_target, o_fired_target);
                    check_field("fired_time", want.fired_time, o_fired_time);
                    check_field("clock_now", want.clock_now, o_clock_now);
                    check_field("pending_count", want.pending_count, o_pending_count);
                    check_field("group_end", want.group_end, o_group_end);
                    check_field("last", want.last, o_last);
                end
                case (tepq_pkg::t_status'(o_status))
                    tepq_pkg::STS_FIRED:   n_fired++;
                    tepq_pkg::STS_FULL:    n_full++;
                    tepq_pkg::STS_EMPTY:   n_empty++;
                    tepq_pkg::STS_NOTHING: n_nothing++;
                    tepq_pkg::STS_CLEARED: n_cleared++;
                    default: ;
                endcase
            end
            // long hold-off once so the queue backs up into the input
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall <= 1'b1;
            end else if (live_phase == PH_PRESSURE && !hold_done) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct[live_phase]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            stuck_cycles <= 0;
        else if ((i_valid && !o_stall) || (o_valid && !i_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    assign timed_out = (stuck_cycles >= WATCHDOG);

    initial begin
        int ph;
        int in_phase;
        int goal_n;
        bit pressed;

        push_req(tepq_pkg::FN_ADV_NEXT, 32'd0, 16'd0, PH_FREE);
        push_req(tepq_pkg::FN_ADV_TIME, 32'd5, 16'd0, PH_FREE);
        push_req(tepq_pkg::FN_INSERT, 32'hFFFF_FFFF, 16'hFFFF, PH_FREE);
        push_req(tepq_pkg::FN_ADV_TIME, 32'd10, 16'd0, PH_FREE);
        push_req(tepq_pkg::FN_INSERT, 32'd0, 16'd0, PH_FREE);
        push_req(tepq_pkg::FN_ADV_NEXT, 32'd0, 16'd0, PH_FREE);
        push_req(tepq_pkg::FN_INSERT, 32'd100, 16'd1, PH_FREE);
        push_req(tepq_pkg::FN_INSERT, 32'd100, 16'd2, PH_FREE);
        push_req(tepq_pkg::FN_INSERT, 32'd100, 16'd3, PH_FREE);
        push_req(tepq_pkg::FN_INSERT, 32'd50, 16'hAAAA, PH_FREE);
        push_req(tepq_pkg::FN_INSERT, 32'd200, 16'h5555, PH_FREE);
        push_req(tepq_pkg::FN_ADV_TIME, 32'd150, 16'd0, PH_FREE);
        push_req(tepq_pkg::FN_ADV_NEXT, 32'd0, 16'd0, PH_FREE);
        push_req(tepq_pkg::FN_ADV_TIME, 32'hFFFF_FFFF, 16'd0, PH_FREE);
        push_req(tepq_pkg::FN_ADV_TIME, 32'd1, 16'd0, PH_FREE);
        push_req(tepq_pkg::FN_INSERT, 32'd7, 16'd7, PH_FREE);
        push_req(tepq_pkg::FN_CLEAR, 32'd0, 16'd0, PH_FREE);
        push_req(tepq_pkg::FN_ADV_NEXT, 32'd0, 16'd0, PH_FREE);

        goal_n = request_q.size() + RANDOM_ITEMS;
        ph = PH_FREE;
        in_phase = 0;
        pressed = 1'b0;
        while (request_q.size() < goal_n) begin
            if (!pressed && request_q.size() >= goal_n / 2) begin
                // fill past capacity under a held-off receiver, then fire everything
                push_req(tepq_pkg::FN_CLEAR, $urandom, $urandom_range(0, 65535),
                         PH_PRESSURE);
                repeat (tepq_pkg::DEPTH + 6)
                    push_req(tepq_pkg::FN_INSERT, $urandom_range(0, 500),
                             $urandom_range(0, 65535), PH_PRESSURE);
                push_req(tepq_pkg::FN_ADV_TIME, 32'hFFFF_FFFF, $urandom_range(0, 65535),
                         PH_PRESSURE);
                push_req(tepq_pkg::FN_CLEAR, $urandom, $urandom_range(0, 65535),
                         PH_PRESSURE);
                pressed = 1'b1;
            end
            if (in_phase >= PHASE_ITEMS) begin
                ph = (ph + 1) % PH_PRESSURE;
                in_phase = 0;
            end
            in_phase -= request_q.size();
            push_burst(ph);
            in_phase += request_q.size();
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!timed_out &&
               (request_q.size() != 0 || i_valid || outcome_q.size() != 0))
            @(posedge i_clk);
        if (!timed_out)
            repeat (DRAIN) @(posedge i_clk);
        if (timed_out)
            $error("no beat accepted for %0d cycles", WATCHDOG);
        if (outcome_q.size() != 0) begin
            $error("%0d expected results never arrived", outcome_q.size());
            err_cnt++;
        end

        $display("requests %0d: fired %0d events, %0d nothing-due, %0d empty,",
                 n_req, n_fired, n_nothing, n_empty);
        $display("  %0d inserts refused on full, %0d clears, %0d mismatches",
                 n_full, n_cleared, err_cnt);
        if (!timed_out && err_cnt == 0)
            $display("tb_timed_event_priority_queue: clean");
        else
            $display("tb_timed_event_priority_queue: errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/tepq_pkg.sv
sv/tepq_cell.sv
sv/tepq_ctrl.sv
sv/timed_event_priority_queue.sv
sv/tepq_checker.sv
tb/tb_timed_event_priority_queue.sv
